// ===== rtl/etd_pkg.sv =====
// shared types and constants of the event, timed and distance photo trigger
// no dependencies; the front, queue, back end and top level import this package
package etd_pkg;

  localparam int unsigned MAX_CAMS   = 8;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;

  localparam int unsigned CAMERAS_DEF = 4;

  localparam logic [7:0] ALARM_BASE  = 8'd224;
  localparam logic [7:0] STATUS_BASE = 8'd192;
  localparam logic [9:0] KM_FACTOR   = 10'd1000;
  localparam logic [5:0] MIN_FACTOR  = 6'd60;
  localparam logic [24:0] MIN_DISTANCE = 25'd100;
  localparam logic [20:0] MIN_TIME   = 21'd5;

  localparam logic [1:0] STORE_ONLY   = 2'd1;
  localparam logic [1:0] STORE_UPLOAD = 2'd2;
  localparam logic [1:0] STORE_BOTH   = 2'd3;

  localparam logic [7:0] EV_TIMED     = 8'd1;
  localparam logic [7:0] EV_COLLISION = 8'd3;
  localparam logic [7:0] EV_DOOR      = 8'd4;
  localparam logic [7:0] EV_DISTANCE  = 8'd7;

  typedef enum logic [7:0] {
    CFG_ALARM_MASK  = 8'd0,
    CFG_STATUS_MASK = 8'd1,
    CFG_TIME_CTL    = 8'd2,
    CFG_DIST_CTL    = 8'd3,
    CFG_TIME_CHAN   = 8'd4,
    CFG_DIST_CHAN   = 8'd5,
    CFG_TIME_OK     = 8'd6,
    CFG_DIST_OK     = 8'd7
  } cfg_index_t;

  // one queued job: either a single event photo or a list of cameras
  typedef struct packed {
    logic                is_event;
    logic [7:0]          chan;
    logic [7:0]          ev;
    logic [MAX_CAMS-1:0] cams;
    logic [MAX_CAMS-1:0] store_kind;
  } job_t;

endpackage

// ===== rtl/etd_ifs.sv =====
// channel interfaces of the photo trigger: tick input, request output, config writes
// no dependencies
interface etd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] alarm_word;
  logic [31:0] status_word;
  logic        second_link_open;
  logic        camera_timed_busy;
  logic [28:0] pulse_mileage;
  logic [28:0] meter_mileage;
  logic        speed_source;

  modport source (output valid, alarm_word, status_word, second_link_open,
                  camera_timed_busy, pulse_mileage, meter_mileage, speed_source,
                  input ready);
  modport sink (input valid, alarm_word, status_word, second_link_open,
                camera_timed_busy, pulse_mileage, meter_mileage, speed_source,
                output ready);
endinterface

interface etd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] channel_mask;
  logic [3:0] camera_id;
  logic [1:0] store_mode;
  logic [7:0] event_type;
  logic       last_of_tick;

  modport source (output valid, channel_mask, camera_id, store_mode, event_type,
                  last_of_tick, input ready);
  modport sink (input valid, channel_mask, camera_id, store_mode, event_type,
                last_of_tick, output ready);
endinterface

interface etd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/etd_front.sv =====
// front end: config registers, tick input register and trigger evaluation
// depends on etd_pkg and the channel interfaces; pushes jobs into etd_queue
module etd_front #(
  parameter int unsigned CAMERAS = etd_pkg::CAMERAS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  etd_in_if.sink            in_ch,
  etd_cfg_if.sink           cfg_ch,
  output logic              job_valid,
  output etd_pkg::job_t     job_data,
  input  logic              job_ready
);
  import etd_pkg::*;

  localparam logic [7:0] CAM_KEEP = 8'((16'd1 << CAMERAS) - 16'd1);

  // config
  logic [31:0] alarm_mask_r, status_mask_r, time_ctl_r, dist_ctl_r;
  logic [7:0]  time_chan_r, dist_chan_r;
  logic        time_ok_r, dist_ok_r;
  logic [20:0] time_space_r;
  logic [24:0] dist_space_r;
  logic [20:0] time_space_nxt;
  logic [24:0] dist_space_nxt;

  // trigger state
  logic [31:0] prev_alarm_r, prev_status_r, sec_r, npd_r;
  logic [31:0] prev_status_nxt, sec_nxt, npd_nxt;

  // tick register
  logic        s1_valid_r;
  logic [31:0] s1_alarm_r, s1_status_r, s1_dist_r;
  logic        s1_link_r, s1_busy_r;
  logic [28:0] mileage;
  logic        s1_adv;

  function automatic logic [5:0] lowest_bit(input logic [31:0] v);
    logic [5:0] idx;
    idx = 6'd32;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  assign cfg_ch.ready = 1'b1;

  // spacing derived at write time so a tick right after a write sees it
  always_comb begin
    logic [20:0] t;
    logic [24:0] d;
    t = {6'd0, cfg_ch.data[31:17]};
    if (cfg_ch.data[16]) t = 21'(t * MIN_FACTOR);
    time_space_nxt = (t < MIN_TIME) ? MIN_TIME : t;
    d = {10'd0, cfg_ch.data[31:17]};
    if (cfg_ch.data[16]) d = 25'(d * KM_FACTOR);
    dist_space_nxt = (d < MIN_DISTANCE) ? MIN_DISTANCE : d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_mask_r  <= '0;
      status_mask_r <= '0;
      time_ctl_r    <= '0;
      dist_ctl_r    <= '0;
      time_chan_r   <= '0;
      dist_chan_r   <= '0;
      time_ok_r     <= 1'b1;
      dist_ok_r     <= 1'b1;
      time_space_r  <= MIN_TIME;
      dist_space_r  <= MIN_DISTANCE;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ALARM_MASK:  alarm_mask_r  <= cfg_ch.data;
        CFG_STATUS_MASK: status_mask_r <= cfg_ch.data;
        CFG_TIME_CTL: begin
          time_ctl_r   <= cfg_ch.data;
          time_space_r <= time_space_nxt;
        end
        CFG_DIST_CTL: begin
          dist_ctl_r   <= cfg_ch.data;
          dist_space_r <= dist_space_nxt;
        end
        CFG_TIME_CHAN:   time_chan_r <= cfg_ch.data[7:0];
        CFG_DIST_CHAN:   dist_chan_r <= cfg_ch.data[7:0];
        CFG_TIME_OK:     time_ok_r   <= cfg_ch.data[0];
        CFG_DIST_OK:     dist_ok_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // tick register: mileage is scaled here, ahead of the state compare
  assign s1_adv      = s1_valid_r && job_ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign mileage     = in_ch.speed_source ? in_ch.meter_mileage : in_ch.pulse_mileage;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_alarm_r  <= in_ch.alarm_word;
      s1_status_r <= in_ch.status_word;
      s1_link_r   <= in_ch.second_link_open;
      s1_busy_r   <= in_ch.camera_timed_busy;
      s1_dist_r   <= (32'(mileage) << 3) + (32'(mileage) << 1);
    end
  end

  // trigger evaluation, first claim ends the tick
  always_comb begin
    logic [31:0] ra, rs, sec_inc;
    logic [5:0]  ba, bs;
    logic [7:0]  ev_chan, tcams, dcams;
    logic        claimed;
    ra      = s1_alarm_r & ~prev_alarm_r & alarm_mask_r;
    rs      = s1_status_r & ~prev_status_r & status_mask_r;
    ba      = lowest_bit(ra);
    bs      = lowest_bit(rs);
    ev_chan = {6'd0, s1_link_r, 1'b1};
    tcams   = time_ctl_r[7:0] & CAM_KEEP;
    dcams   = dist_ctl_r[7:0] & CAM_KEEP;
    sec_inc = sec_r + 32'd1;
    claimed = 1'b0;
    job_valid       = 1'b0;
    job_data        = '0;
    prev_status_nxt = prev_status_r;
    sec_nxt         = sec_r;
    npd_nxt         = npd_r;

    // a new emergency bit (bit 0) gives no alarm photo, even with other new alarm bits
    if (ra != '0 && ba != 6'd0) begin
      claimed           = 1'b1;
      job_valid         = 1'b1;
      job_data.is_event = 1'b1;
      job_data.chan     = ev_chan;
      job_data.ev       = (ba == 6'd29 || ba == 6'd30) ? EV_COLLISION
                                                       : ALARM_BASE + {2'd0, ba};
    end

    if (!claimed) begin
      prev_status_nxt = s1_status_r;
      if (rs != '0 && bs != 6'd1 && bs != 6'd2 && bs != 6'd3 && bs != 6'd5) begin
        claimed           = 1'b1;
        job_valid         = 1'b1;
        job_data.is_event = 1'b1;
        job_data.chan     = ev_chan;
        job_data.ev       = (bs >= 6'd13 && bs <= 6'd17) ? EV_DOOR
                                                         : STATUS_BASE + {2'd0, bs};
      end
    end

    if (!claimed && !time_ok_r) claimed = 1'b1;

    if (!claimed) begin
      if (sec_inc >= {11'd0, time_space_r}) begin
        sec_nxt = '0;
        if (s1_busy_r) begin
          claimed = 1'b1;
        end else if (tcams != '0) begin
          claimed             = 1'b1;
          job_valid           = 1'b1;
          job_data.chan       = time_chan_r;
          job_data.ev         = EV_TIMED;
          job_data.cams       = tcams;
          job_data.store_kind = time_ctl_r[15:8];
        end
      end else begin
        sec_nxt = sec_inc;
      end
    end

    if (!claimed && !dist_ok_r) claimed = 1'b1;

    if (!claimed && s1_dist_r >= npd_r) begin
      npd_nxt = s1_dist_r + {7'd0, dist_space_r};
      if (dcams != '0) begin
        job_valid           = 1'b1;
        job_data.chan       = dist_chan_r;
        job_data.ev         = EV_DISTANCE;
        job_data.cams       = dcams;
        job_data.store_kind = dist_ctl_r[15:8];
      end
    end

    job_valid = job_valid && s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_alarm_r  <= '0;
      prev_status_r <= '0;
      sec_r         <= '0;
      npd_r         <= '0;
    end else if (s1_adv) begin
      // prev_alarm always ends up equal to the last alarm word
      prev_alarm_r  <= s1_alarm_r;
      prev_status_r <= prev_status_nxt;
      sec_r         <= sec_nxt;
      npd_r         <= npd_nxt;
    end
  end

endmodule

// ===== rtl/etd_queue.sv =====
// short job queue between trigger evaluation and request output
// depends on etd_pkg for the job type
module etd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  etd_pkg::job_t push_data,
  output logic          push_ready,
  output logic          pop_valid,
  output etd_pkg::job_t pop_data,
  input  logic          pop_ready
);
  import etd_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) count_r <= count_r + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (QPTR_W+1)'(1);
    end
  end

endmodule

// ===== rtl/etd_back.sv =====
// back end: walks a job's camera list and drives the request output register
// depends on etd_pkg and the output channel interface
module etd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  etd_pkg::job_t job_data,
  output logic          job_ready,
  etd_out_if.source     out_ch
);
  import etd_pkg::*;

  logic       busy_r;
  job_t       job_r;
  logic       out_valid_r;
  logic [7:0] chan_r, ev_r;
  logic [3:0] cam_r;
  logic [1:0] store_r;
  logic       last_r;

  logic                slot_free, emit, finish;
  logic [2:0]          idx;
  logic [MAX_CAMS-1:0] rem;

  always_comb begin
    idx = '0;
    for (int i = MAX_CAMS - 1; i >= 0; i--) begin
      if (job_r.cams[i]) idx = 3'(i);
    end
    rem = job_r.cams & ~(MAX_CAMS'(1) << idx);
  end

  assign slot_free = !out_valid_r || out_ch.ready;
  assign emit      = busy_r && slot_free;
  assign finish    = emit && (job_r.is_event || rem == '0);
  assign job_ready = !busy_r || finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_ready) busy_r <= job_valid;
      if (slot_free) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      job_r <= job_data;
    end else if (emit) begin
      job_r.cams <= rem;
    end
    if (emit) begin
      chan_r <= job_r.chan;
      ev_r   <= job_r.ev;
      if (job_r.is_event) begin
        cam_r   <= 4'd0;
        store_r <= STORE_BOTH;
        last_r  <= 1'b1;
      end else begin
        cam_r   <= {1'b0, idx} + 4'd1;
        store_r <= job_r.store_kind[idx] ? STORE_ONLY : STORE_UPLOAD;
        last_r  <= (rem == '0);
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.channel_mask = chan_r;
  assign out_ch.camera_id    = cam_r;
  assign out_ch.store_mode   = store_r;
  assign out_ch.event_type   = ev_r;
  assign out_ch.last_of_tick = last_r;

endmodule

// ===== rtl/event_timed_distance_photo_trigger.sv =====
// top level of the event, timed and distance photo trigger
// depends on etd_pkg, the channel interfaces, etd_front, etd_queue and etd_back
//
//  channel  dir  moves per transfer
//  in_ch    in   one tick: alarm/status words, link, busy, mileages, source
//  out_ch   out  one photo request: channel, camera, store mode, event, last
//  cfg_ch   in   one register write: index 0..7, 32-bit data (ready always high)
//
// a tick can be taken every cycle while the queue has room; it is held in the
// input register, evaluated against the trigger state and queued as a job (2
// entries) if it gives a photo; the back end loads the job into its job register
// and drives one request per camera (up to CAMERAS), or one for an event job
// rst_n is synchronous: config returns to reset values, trigger state clears
// a stalled output holds its register; the queue lets the front keep taking ticks
module event_timed_distance_photo_trigger #(
  parameter int unsigned CAMERAS = etd_pkg::CAMERAS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  etd_in_if.sink     in_ch,
  etd_out_if.source  out_ch,
  etd_cfg_if.sink    cfg_ch
);
  import etd_pkg::*;

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_data, qb_data;

  etd_front #(.CAMERAS(CAMERAS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .job_valid (fq_valid),
    .job_data  (fq_data),
    .job_ready (fq_ready)
  );

  etd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_data  (fq_data),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_data   (qb_data),
    .pop_ready  (qb_ready)
  );

  etd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_data  (qb_data),
    .job_ready (qb_ready),
    .out_ch    (out_ch)
  );

endmodule
